// ===== src/ort_pkg.sv =====
// shared constants and helpers for the oriented rectangle overlap test
`default_nettype none
package ort_pkg;

	localparam int TRIG_W = 16;
	localparam int X_W = 25;
	localparam int PROD_W = 51;
	localparam int POLY_W = 26;
	localparam int SINE_LAT = 8;
	localparam int AXIS_LAT = 5;

	localparam logic [X_W-1:0] ONE_Q24 = 25'd16777216;
	localparam logic [POLY_W-1:0] SIN_C1 = 26'd26353589;
	localparam logic [POLY_W-1:0] SIN_C3 = 26'd10837479;
	localparam logic [POLY_W-1:0] SIN_C5 = 26'd1337020;
	localparam logic [POLY_W-1:0] SIN_C7 = 26'd78546;
	localparam logic [POLY_W-1:0] SIN_C9 = 26'd2692;
	localparam logic [16:0] ONE_Q14 = 17'd16384;
	localparam logic [16:0] ROUND_HALF = 17'd512;

	// one horner step: coefficient minus the truncated previous product
	function automatic logic [POLY_W-1:0] horner(input logic [POLY_W-1:0] c,
		input logic [PROD_W-1:0] t);
		logic [POLY_W:0] d;
		d = {1'b0, c} - t[PROD_W-1:24];
		return d[POLY_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/ort_req_if.sv =====
// request channel carrying one pair of rectangles
`default_nettype none
interface ort_req_if #(
	parameter int COORD_BITS = 16,
	parameter int ANGLE_BITS = 16
) ();
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] first_left;
	logic signed [COORD_BITS-1:0] first_top;
	logic [COORD_BITS-2:0] first_width;
	logic [COORD_BITS-2:0] first_height;
	logic [ANGLE_BITS-1:0] first_angle;
	logic signed [COORD_BITS-1:0] second_left;
	logic signed [COORD_BITS-1:0] second_top;
	logic [COORD_BITS-2:0] second_width;
	logic [COORD_BITS-2:0] second_height;
	logic [ANGLE_BITS-1:0] second_angle;

	modport source(output valid, first_left, first_top, first_width, first_height,
		first_angle, second_left, second_top, second_width, second_height,
		second_angle, input ready);
	modport sink(input valid, first_left, first_top, first_width, first_height,
		first_angle, second_left, second_top, second_width, second_height,
		second_angle, output ready);
endinterface
`default_nettype wire

// ===== src/ort_res_if.sv =====
// result channel carrying the overlap flag
`default_nettype none
interface ort_res_if ();
	logic valid;
	logic ready;
	logic collide;

	modport source(output valid, collide, input ready);
	modport sink(input valid, collide, output ready);
endinterface
`default_nettype wire

// ===== src/ort_sine.sv =====
// pipelined q1.14 sine of a binary angle, odd degree nine polynomial
`default_nettype none
module ort_sine import ort_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [ANGLE_BITS-1:0]    angle,
	output logic signed [TRIG_W-1:0]      sine
);

	logic [X_W-1:0] xf;
	logic [X_W-1:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [X_W-1:0] x2_s3, x2_s4, x2_s5;
	logic [1:0] q_s1, q_s2, q_s3, q_s4, q_s5, q_s6, q_s7;
	logic [PROD_W-1:0] xx_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [X_W-1:0] x2;
	logic [16:0] rnd, mag;

	assign xf = X_W'(angle[ANGLE_BITS-3:0]) << (26 - ANGLE_BITS);
	assign x2 = xx_s2[48:24];
	assign rnd = (t_s7[PROD_W-1:24] + 27'(ROUND_HALF)) >> 10 > 27'(ONE_Q14) ? ONE_Q14
		: 17'((t_s7[PROD_W-1:24] + 27'(ROUND_HALF)) >> 10);
	assign mag = rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			// odd quadrants run the fraction backwards
			x_s1 <= angle[ANGLE_BITS-2] ? ONE_Q24 - xf : xf;
			q_s1 <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
			xx_s2 <= PROD_W'(x_s1) * PROD_W'(x_s1);
			x_s2 <= x_s1;
			q_s2 <= q_s1;
			t_s3 <= PROD_W'(x2) * PROD_W'(SIN_C9);
			x2_s3 <= x2;
			x_s3 <= x_s2;
			q_s3 <= q_s2;
			t_s4 <= PROD_W'(x2_s3) * PROD_W'(horner(SIN_C7, t_s3));
			x2_s4 <= x2_s3;
			x_s4 <= x_s3;
			q_s4 <= q_s3;
			t_s5 <= PROD_W'(x2_s4) * PROD_W'(horner(SIN_C5, t_s4));
			x2_s5 <= x2_s4;
			x_s5 <= x_s4;
			q_s5 <= q_s4;
			t_s6 <= PROD_W'(x2_s5) * PROD_W'(horner(SIN_C3, t_s5));
			x_s6 <= x_s5;
			q_s6 <= q_s5;
			t_s7 <= PROD_W'(x_s6) * PROD_W'(horner(SIN_C1, t_s6));
			q_s7 <= q_s6;
			sine <= q_s7[1] ? -$signed(TRIG_W'(mag)) : $signed(TRIG_W'(mag));
		end
	end

endmodule
`default_nettype wire

// ===== src/ort_axis.sv =====
// overlap of both rectangles' projections on one axis
`default_nettype none
module ort_axis import ort_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic signed [TRIG_W-1:0]   ax,
	input  wire logic signed [TRIG_W-1:0]   ay,
	input  wire logic signed [TRIG_W-1:0]   sin_a,
	input  wire logic signed [TRIG_W-1:0]   cos_a,
	input  wire logic signed [TRIG_W-1:0]   sin_b,
	input  wire logic signed [TRIG_W-1:0]   cos_b,
	input  wire logic signed [COORD_BITS+1:0] mx_a,
	input  wire logic signed [COORD_BITS+1:0] my_a,
	input  wire logic signed [COORD_BITS+1:0] mx_b,
	input  wire logic signed [COORD_BITS+1:0] my_b,
	input  wire logic [COORD_BITS-2:0]      w_a,
	input  wire logic [COORD_BITS-2:0]      h_a,
	input  wire logic [COORD_BITS-2:0]      w_b,
	input  wire logic [COORD_BITS-2:0]      h_b,
	output logic                            ok
);

	localparam int MW = COORD_BITS + 2;
	localparam int UW = 2 * TRIG_W + 1;
	localparam int PW = MW + TRIG_W + 1;
	localparam int EW = COORD_BITS - 1 + UW;
	localparam int CW = COORD_BITS + 34;

	logic signed [TRIG_W-1:0] sin_r [2];
	logic signed [TRIG_W-1:0] cos_r [2];
	logic signed [MW-1:0] mx_r [2];
	logic signed [MW-1:0] my_r [2];
	logic [COORD_BITS-2:0] w_r [2];
	logic [COORD_BITS-2:0] h_r [2];

	logic signed [2*TRIG_W-1:0] cax_s1 [2], say_s1 [2], sax_s1 [2], cay_s1 [2];
	logic signed [MW+TRIG_W-1:0] pmx_s1 [2], pmy_s1 [2];
	logic [COORD_BITS-2:0] w_s1 [2], h_s1 [2], w_s2 [2], h_s2 [2];
	logic signed [UW-1:0] u_s2 [2], v_s2 [2];
	logic signed [PW-1:0] p_s2 [2], p_s3 [2];
	logic [UW-1:0] ua [2], va [2];
	logic [EW-1:0] eu_s3 [2], ev_s3 [2];
	logic [CW-1:0] esum_s4;
	logic signed [PW:0] pd_s4;
	logic [PW:0] pda;

	assign sin_r = '{sin_a, sin_b};
	assign cos_r = '{cos_a, cos_b};
	assign mx_r = '{mx_a, mx_b};
	assign my_r = '{my_a, my_b};
	assign w_r = '{w_a, w_b};
	assign h_r = '{h_a, h_b};

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			ua[r] = u_s2[r][UW-1] ? UW'(-u_s2[r]) : UW'(u_s2[r]);
			va[r] = v_s2[r][UW-1] ? UW'(-v_s2[r]) : UW'(v_s2[r]);
		end
		pda = pd_s4[PW] ? (PW+1)'(-pd_s4) : (PW+1)'(pd_s4);
	end

	// centre projection p and half extent w|u| + h|v| along the axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 2; r++) begin
				cax_s1[r] <= cos_r[r] * ax;
				say_s1[r] <= sin_r[r] * ay;
				sax_s1[r] <= sin_r[r] * ax;
				cay_s1[r] <= cos_r[r] * ay;
				pmx_s1[r] <= mx_r[r] * ax;
				pmy_s1[r] <= my_r[r] * ay;
				w_s1[r] <= w_r[r];
				h_s1[r] <= h_r[r];
				u_s2[r] <= cax_s1[r] + say_s1[r];
				v_s2[r] <= cay_s1[r] - sax_s1[r];
				p_s2[r] <= pmx_s1[r] + pmy_s1[r];
				w_s2[r] <= w_s1[r];
				h_s2[r] <= h_s1[r];
				eu_s3[r] <= EW'(w_s2[r]) * EW'(ua[r]);
				ev_s3[r] <= EW'(h_s2[r]) * EW'(va[r]);
				p_s3[r] <= p_s2[r];
			end
			esum_s4 <= CW'(eu_s3[0]) + CW'(ev_s3[0]) + CW'(eu_s3[1]) + CW'(ev_s3[1]);
			pd_s4 <= p_s3[0] - p_s3[1];
			// extents carry one extra factor of 16384
			ok <= (CW'(pda) << 14) <= esum_s4;
		end
	end

endmodule
`default_nettype wire

// ===== src/oriented_rect_overlap_test.sv =====
// top level: separating axis overlap test for two rotated rectangles
// Takes one rectangle pair per cycle while the pipeline moves, and answers
// after eight stages of the sine polynomial and five of the axis projection
// and compare. Touching rectangles count as overlapping. The whole
// pipeline moves only while the output register is empty or being taken.
`default_nettype none
module oriented_rect_overlap_test import ort_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ort_req_if.sink   req,
	ort_res_if.source res
);

	localparam int LAT = SINE_LAT + AXIS_LAT;
	localparam int MW = COORD_BITS + 2;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	typedef struct packed {
		logic signed [MW-1:0] mx;
		logic signed [MW-1:0] my;
		logic [COORD_BITS-2:0] w;
		logic [COORD_BITS-2:0] h;
	} geo_t;

	logic en;
	logic [LAT-1:0] vld_q;
	geo_t geo_in [2];
	geo_t geo_q [SINE_LAT][2];
	logic signed [TRIG_W-1:0] s_a, c_a, s_b, c_b;
	logic signed [TRIG_W-1:0] ax [4];
	logic signed [TRIG_W-1:0] ay [4];
	logic [3:0] ok;
	logic wa, ha, wb, hb;

	assign en = !vld_q[LAT-1] || res.ready;
	assign req.ready = en;
	assign res.valid = vld_q[LAT-1];
	assign res.collide = &ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	// doubled centre coordinates, exact
	assign geo_in[0].mx = $signed({req.first_left[COORD_BITS-1], req.first_left, 1'b0}
		+ {3'b000, req.first_width});
	assign geo_in[0].my = $signed({req.first_top[COORD_BITS-1], req.first_top, 1'b0}
		+ {3'b000, req.first_height});
	assign geo_in[0].w = req.first_width;
	assign geo_in[0].h = req.first_height;
	assign geo_in[1].mx = $signed({req.second_left[COORD_BITS-1], req.second_left, 1'b0}
		+ {3'b000, req.second_width});
	assign geo_in[1].my = $signed({req.second_top[COORD_BITS-1], req.second_top, 1'b0}
		+ {3'b000, req.second_height});
	assign geo_in[1].w = req.second_width;
	assign geo_in[1].h = req.second_height;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_q[0] <= geo_in;
			for (int k = 1; k < SINE_LAT; k++) begin
				geo_q[k] <= geo_q[k-1];
			end
		end
	end

	ort_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_a (.clk(clk), .en(en),
		.angle(req.first_angle), .sine(s_a));
	ort_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_a (.clk(clk), .en(en),
		.angle(req.first_angle + QUARTER), .sine(c_a));
	ort_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_b (.clk(clk), .en(en),
		.angle(req.second_angle), .sine(s_b));
	ort_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_b (.clk(clk), .en(en),
		.angle(req.second_angle + QUARTER), .sine(c_b));

	// opposite normals give the same test, so two axes per rectangle suffice;
	// a zero-length edge gives a zero axis, which never separates
	assign wa = geo_q[SINE_LAT-1][0].w != '0;
	assign ha = geo_q[SINE_LAT-1][0].h != '0;
	assign wb = geo_q[SINE_LAT-1][1].w != '0;
	assign hb = geo_q[SINE_LAT-1][1].h != '0;
	assign ax[0] = wa ? s_a : '0;
	assign ay[0] = wa ? -c_a : '0;
	assign ax[1] = ha ? c_a : '0;
	assign ay[1] = ha ? s_a : '0;
	assign ax[2] = wb ? s_b : '0;
	assign ay[2] = wb ? -c_b : '0;
	assign ax[3] = hb ? c_b : '0;
	assign ay[3] = hb ? s_b : '0;

	for (genvar k = 0; k < 4; k++) begin : g_axis
		ort_axis #(.COORD_BITS(COORD_BITS)) u_axis (
			.clk(clk), .en(en), .ax(ax[k]), .ay(ay[k]),
			.sin_a(s_a), .cos_a(c_a), .sin_b(s_b), .cos_b(c_b),
			.mx_a(geo_q[SINE_LAT-1][0].mx), .my_a(geo_q[SINE_LAT-1][0].my),
			.mx_b(geo_q[SINE_LAT-1][1].mx), .my_b(geo_q[SINE_LAT-1][1].my),
			.w_a(geo_q[SINE_LAT-1][0].w), .h_a(geo_q[SINE_LAT-1][0].h),
			.w_b(geo_q[SINE_LAT-1][1].w), .h_b(geo_q[SINE_LAT-1][1].h),
			.ok(ok[k]));
	end

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_q[0])
		else $error("accepted request did not enter the pipeline");
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> vld_q[LAT-1:1] == $past(vld_q[LAT-2:0]))
		else $error("valid bits did not advance together");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ===== dv/tb_oriented_rect_overlap_test.sv =====
// testbench for the oriented rectangle overlap test: random and directed rectangle pairs
module tb_oriented_rect_overlap_test;
	import ort_pkg::*;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0] width;
		logic [14:0] height;
		logic [15:0] angle;
	} rect_t;

	typedef struct {
		rect_t a;
		rect_t b;
	} pair_t;

	logic clk;
	logic arst_n;
	bit quiet;
	int mismatches;
	int ready_hold;
	bit expected_hits[$];

	ort_req_if #(.COORD_BITS(16), .ANGLE_BITS(16)) req ();
	ort_res_if res ();

	oriented_rect_overlap_test #(.COORD_BITS(16), .ANGLE_BITS(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// q1.14 sine of a binary angle, polynomial over the quarter turn
	function automatic longint sine_q14(input logic [15:0] a);
		logic [63:0] x, x2, p, s;
		x = {40'd0, a[13:0], 10'd0};
		if (a[14]) begin
			x = 64'd16777216 - x;
		end
		x2 = (x * x) >> 24;
		p = 64'd2692;
		p = 64'd78546 - ((x2 * p) >> 24);
		p = 64'd1337020 - ((x2 * p) >> 24);
		p = 64'd10837479 - ((x2 * p) >> 24);
		p = 64'd26353589 - ((x2 * p) >> 24);
		s = (x * p) >> 24;
		s = (s + 64'd512) >> 10;
		if (s > 64'd16384) begin
			s = 64'd16384;
		end
		return a[15] ? -longint'(s) : longint'(s);
	endfunction

	// rotated corners (doubled units, scaled by q1.14) and a normal for each edge
	function automatic void rect_shape(input rect_t r, output longint cx[4],
		output longint cy[4], output longint ax[4], output longint ay[4]);
		longint s, c, w, h, mx, my, dx, dy;
		s = sine_q14(r.angle);
		c = sine_q14(r.angle + 16'd16384);
		w = longint'(r.width);
		h = longint'(r.height);
		mx = (2 * longint'(r.left) + w) * 16384;
		my = (2 * longint'(r.top) + h) * 16384;
		for (int k = 0; k < 4; k++) begin
			dx = (k == 0 || k == 3) ? -w : w;
			dy = (k < 2) ? -h : h;
			cx[k] = mx + dx * c - dy * s;
			cy[k] = my + dx * s + dy * c;
		end
		ax[0] = (w != 0) ? s : 0;  ay[0] = (w != 0) ? -c : 0;
		ax[1] = (h != 0) ? c : 0;  ay[1] = (h != 0) ? s : 0;
		ax[2] = (w != 0) ? -s : 0; ay[2] = (w != 0) ? c : 0;
		ax[3] = (h != 0) ? -c : 0; ay[3] = (h != 0) ? -s : 0;
	endfunction

	function automatic bit pair_collides(input pair_t p);
		longint ax1[4], ay1[4], cx1[4], cy1[4];
		longint ax2[4], ay2[4], cx2[4], cy2[4];
		longint nx, ny, v, lo1, hi1, lo2, hi2;
		bit hit;
		hit = 1'b1;
		rect_shape(p.a, cx1, cy1, ax1, ay1);
		rect_shape(p.b, cx2, cy2, ax2, ay2);
		for (int n = 0; n < 8; n++) begin
			nx = (n < 4) ? ax1[n] : ax2[n-4];
			ny = (n < 4) ? ay1[n] : ay2[n-4];
			for (int k = 0; k < 4; k++) begin
				v = cx1[k] * nx + cy1[k] * ny;
				if (k == 0 || v < lo1) lo1 = v;
				if (k == 0 || v > hi1) hi1 = v;
				v = cx2[k] * nx + cy2[k] * ny;
				if (k == 0 || v < lo2) lo2 = v;
				if (k == 0 || v > hi2) hi2 = v;
			end
			if (hi1 < lo2 || hi2 < lo1) hit = 1'b0;
		end
		return hit;
	endfunction

	// result side: random stall bursts unless quiet
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			res.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			ready_hold <= $urandom_range(0, 10);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result collide=%0b", res.collide);
			end else begin
				if (res.collide !== expected_hits[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("collide mismatch: expected %0b actual %0b",
							expected_hits[0], res.collide);
				end
				void'(expected_hits.pop_front());
			end
		end
	end

	task automatic send_pair(input pair_t p);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req.first_left = p.a.left;
		req.first_top = p.a.top;
		req.first_width = p.a.width;
		req.first_height = p.a.height;
		req.first_angle = p.a.angle;
		req.second_left = p.b.left;
		req.second_top = p.b.top;
		req.second_width = p.b.width;
		req.second_height = p.b.height;
		req.second_angle = p.b.angle;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		expected_hits = {expected_hits, pair_collides(p)};
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_hits.size() != 0) @(posedge clk);
	endtask

	function automatic rect_t make_rect(input int l, input int t, input int w, input int h,
		input int ang);
		rect_t r;
		r.left = l[15:0];
		r.top = t[15:0];
		r.width = w[14:0];
		r.height = h[14:0];
		r.angle = ang[15:0];
		return r;
	endfunction

	function automatic rect_t rand_rect_wide();
		return make_rect($urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// rectangles clustered around a random spot so both answers are common
	function automatic rect_t rand_rect_near(input int cx, input int cy);
		int w, h;
		w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 2047);
		h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 2047);
		if ($urandom_range(0, 20) == 0) w = 32767;
		return make_rect(cx + $urandom_range(0, 4000) - 2000, cy + $urandom_range(0, 4000) - 2000,
			w, h, ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 3) * 16384) : $urandom);
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int cx, cy;
		if ($urandom_range(0, 7) == 0) begin
			p.a = rand_rect_wide();
			p.b = rand_rect_wide();
		end else begin
			cx = $urandom_range(0, 60000) - 30000;
			cy = $urandom_range(0, 60000) - 30000;
			p.a = rand_rect_near(cx, cy);
			p.b = rand_rect_near(cx, cy);
		end
		return p;
	endfunction

	task automatic test_directed();
		pair_t p;
		// identical squares
		p.a = make_rect(0, 0, 160, 160, 0); p.b = p.a; send_pair(p);
		// edges touching exactly, then a one-unit gap
		p.b = make_rect(160, 0, 160, 160, 0); send_pair(p);
		p.b = make_rect(161, 0, 160, 160, 0); send_pair(p);
		p.b = make_rect(0, 160, 160, 160, 0); send_pair(p);
		p.b = make_rect(0, 161, 160, 160, 0); send_pair(p);
		// rotation brings a separated pair into contact
		p.a = make_rect(0, 0, 320, 32, 16384); p.b = make_rect(180, 0, 32, 32, 0); send_pair(p);
		p.a = make_rect(0, 0, 320, 32, 8192); send_pair(p);
		p.a = make_rect(0, 0, 320, 32, 32768); send_pair(p);
		p.a = make_rect(0, 0, 320, 32, 49152); send_pair(p);
		p.a = make_rect(0, 0, 320, 32, 65535); send_pair(p);
		// zero sizes: degenerate point and segment
		p.a = make_rect(100, 100, 0, 0, 0); p.b = make_rect(0, 0, 200, 200, 0); send_pair(p);
		p.a = make_rect(300, 100, 0, 0, 4000); send_pair(p);
		p.a = make_rect(-50, 100, 400, 0, 12345); send_pair(p);
		p.a = make_rect(100, -50, 0, 400, 40000); send_pair(p);
		p.a = make_rect(0, 0, 0, 0, 0); p.b = p.a; send_pair(p);
		// field extremes
		p.a = make_rect(-32768, -32768, 32767, 32767, 0);
		p.b = make_rect(32767, 32767, 32767, 32767, 65535); send_pair(p);
		p.a = make_rect(32767, -32768, 0, 32767, 16383);
		p.b = make_rect(-32768, 32767, 32767, 0, 16385); send_pair(p);
		p.a = make_rect(-32768, -32768, 32767, 32767, 32768);
		p.b = make_rect(-32768, -32768, 1, 1, 49152); send_pair(p);
		p.a = make_rect(32767, 32767, 32767, 32767, 1);
		p.b = make_rect(-32768, -32768, 32767, 32767, 65534); send_pair(p);
	endtask

	task automatic test_random_stream(input int count);
		for (int i = 0; i < count; i++) send_pair(rand_pair());
	endtask

	task automatic test_pause_until_drained();
		test_random_stream(40);
		req.valid = 1'b0;
		wait_drained();
		@(negedge clk);
		test_random_stream(40);
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		test_random_stream(300);
	endtask

	initial begin
		arst_n = 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		ready_hold = 0;
		req.valid = 1'b0;
		req.first_left = '0;
		req.first_top = '0;
		req.first_width = '0;
		req.first_height = '0;
		req.first_angle = '0;
		req.second_left = '0;
		req.second_top = '0;
		req.second_width = '0;
		req.second_height = '0;
		req.second_angle = '0;
		res.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_stream(1250);
		test_pause_until_drained();
		test_back_to_back();
		req.valid = 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_hits.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/ort_pkg.sv
src/ort_req_if.sv
src/ort_res_if.sv
src/ort_sine.sv
src/ort_axis.sv
src/oriented_rect_overlap_test.sv
dv/tb_oriented_rect_overlap_test.sv
